FILE: sv/crconv_pkg.sv
package crconv_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam int VALUE_W = 64;
    localparam int TIME_W  = 48;
    // product width of a 64-bit magnitude by 1000 (< 2^10)
    localparam int PROD_W  = VALUE_W + 10;

    localparam logic [1:0] KIND_GAUGE    = 2'd0;
    localparam logic [1:0] KIND_COUNTER  = 2'd1;
    localparam logic [1:0] KIND_DERIVE   = 2'd2;
    localparam logic [1:0] KIND_ABSOLUTE = 2'd3;

    localparam logic [1:0] MODE_IGNORE  = 2'd0;
    localparam logic [1:0] MODE_DISCARD = 2'd1;
    localparam logic [1:0] MODE_CLAMP   = 2'd2;

    localparam logic [1:0] STATUS_VALID   = 2'd0;
    localparam logic [1:0] STATUS_NONE    = 2'd1;
    localparam logic [1:0] STATUS_DISCARD = 2'd2;
    localparam logic [1:0] STATUS_SAT     = 2'd3;

    localparam logic [1:0] REG_SOURCE_KIND = 2'd0;
    localparam logic [1:0] REG_RANGE_MODE  = 2'd1;
    localparam logic [1:0] REG_MIN_RATE    = 2'd2;
    localparam logic [1:0] REG_MAX_RATE    = 2'd3;

    localparam logic [63:0] RATE_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] RATE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [32:0] WRAP32   = 33'h1_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIFF,
        ST_MAG,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_SAT,
        ST_BOUND,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]  sample_time;
        logic [VALUE_W-1:0] sample_value;
        logic               value_present;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] rate;
        logic [1:0]         status;
    } out_item_t;

endpackage

FILE: sv/counter_rate_converter_unit.sv
// Converts timestamped counter samples (ms) into a per-second rate in signed fixed point
// with FRACTION_BITS fraction bits, one result per item. Missing values, refused samples
// and a first counter or derive sample go from the check state straight to output, and
// gauge items through the bound state; other counter, derive and absolute items pass the
// diff, magnitude and two multiply states and a one-bit-per-cycle restoring divider over
// the scaled difference or value, then saturation and bounds. The next item is taken
// only back in idle. s_ready is high only while the unit is idle; the
// output register lets a new item enter while the last result waits. Configuration writes
// are taken at any time but must be issued only while the unit is idle.
module counter_rate_converter_unit
    import crconv_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int DIV_W = PROD_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(DIV_W + 1);

    state_t state_reg, state_next;

    logic [1:0]  kind_reg;
    logic [1:0]  mode_reg;
    logic [63:0] min_reg;
    logic [63:0] max_reg;

    in_item_t    item_reg;
    logic [TIME_W-1:0]  prev_time_reg,  prev_time_next;
    logic [VALUE_W-1:0] prev_value_reg, prev_value_next;
    logic               prev_known_reg, prev_known_next;

    logic [TIME_W-1:0]  dt_reg,  dt_next;
    logic [63:0]        d_reg,   d_next;
    logic [63:0]        nd_reg,  nd_next;
    logic               borrow_reg, borrow_next;
    logic [63:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [DIV_W-1:0]   acc_reg, acc_next;
    logic [TIME_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [63:0]        rate_reg, rate_next;
    logic [1:0]         status_reg, status_next;
    logic               sat_reg, sat_next;

    logic      m_valid_reg, m_valid_next;
    out_item_t out_reg, out_next;

    logic refused;
    logic early_out;
    logic no_prev;
    logic out_space;
    logic [64:0]      sub_vp;
    logic [PROD_W-1:0] mag_ext;
    logic [PROD_W-1:0] prod;
    logic [TIME_W:0]  rem_sh;
    logic [TIME_W:0]  rem_diff;
    logic             rem_ge;
    logic             q_hi;
    logic [63:0]      q_lo;
    logic             below;
    logic             above;

    assign refused   = (kind_reg != KIND_GAUGE) && (prev_time_reg >= item_reg.sample_time);
    assign early_out = !item_reg.value_present || refused;
    assign no_prev   = ((kind_reg == KIND_COUNTER) || (kind_reg == KIND_DERIVE))
                       && !prev_known_reg;
    assign out_space = !m_valid_reg || m_ready;

    assign sub_vp   = {1'b0, item_reg.sample_value} - {1'b0, prev_value_reg};
    assign mag_ext  = PROD_W'(mag_reg);
    assign prod     = (mag_ext << 10) - (mag_ext << 4);
    assign rem_sh   = {rem_reg, acc_reg[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, dt_reg};
    assign rem_ge   = rem_sh >= {1'b0, dt_reg};
    assign q_hi     = (acc_reg >> 64) != '0;
    assign q_lo     = acc_reg[63:0];
    assign below    = $signed(rate_reg) < $signed(min_reg);
    assign above    = !below && ($signed(max_reg) < $signed(rate_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (early_out || no_prev) begin
                    state_next = ST_OUT;
                end else if (kind_reg == KIND_GAUGE) begin
                    state_next = ST_BOUND;
                end else begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:  state_next = ST_MAG;
            ST_MAG:   state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:   state_next = ST_BOUND;
            ST_BOUND: state_next = ST_OUT;
            ST_OUT: begin
                if (out_space) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready   = 1'b0;
        cfg_ready = 1'b1;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            default: s_ready = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        prev_time_next  = prev_time_reg;
        prev_value_next = prev_value_reg;
        prev_known_next = prev_known_reg;
        dt_next     = dt_reg;
        d_next      = d_reg;
        nd_next     = nd_reg;
        borrow_next = borrow_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        rate_next   = rate_reg;
        status_next = status_reg;
        sat_next    = sat_reg;
        out_next    = out_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_CHECK: begin
                rate_next   = '0;
                status_next = STATUS_NONE;
                sat_next    = 1'b0;
                if (!early_out && (kind_reg == KIND_GAUGE || no_prev)) begin
                    prev_time_next  = item_reg.sample_time;
                    prev_value_next = item_reg.sample_value;
                    prev_known_next = 1'b1;
                end
                if (!early_out && kind_reg == KIND_GAUGE) begin
                    if ((item_reg.sample_value >> (63 - FRACTION_BITS)) != '0) begin
                        sat_next  = 1'b1;
                        rate_next = RATE_MAX;
                    end else begin
                        rate_next = item_reg.sample_value << FRACTION_BITS;
                    end
                end
            end
            ST_DIFF: begin
                dt_next     = item_reg.sample_time - prev_time_reg;
                d_next      = sub_vp[63:0];
                nd_next     = prev_value_reg - item_reg.sample_value;
                borrow_next = sub_vp[64];
                prev_time_next  = item_reg.sample_time;
                prev_value_next = item_reg.sample_value;
                prev_known_next = 1'b1;
            end
            ST_MAG: begin
                neg_next = 1'b0;
                unique case (kind_reg)
                    KIND_COUNTER: begin
                        if (borrow_reg && nd_reg[63:33] == '0
                            && (!nd_reg[32] || nd_reg[31:0] == '0)) begin
                            mag_next = 64'(WRAP32 - nd_reg[32:0]);
                        end else begin
                            mag_next = d_reg;
                        end
                    end
                    KIND_DERIVE: begin
                        mag_next = borrow_reg ? nd_reg : d_reg;
                        neg_next = borrow_reg;
                    end
                    default: mag_next = item_reg.sample_value;
                endcase
            end
            ST_MUL1: begin
                acc_next = DIV_W'(prod);
            end
            ST_MUL2: begin
                acc_next = DIV_W'(acc_reg[PROD_W-1:0] - (mag_ext << 3)) << FRACTION_BITS;
                rem_next = '0;
                cnt_next = CNT_W'(DIV_W);
            end
            ST_DIV: begin
                rem_next = rem_ge ? rem_diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
                acc_next = {acc_reg[DIV_W-2:0], rem_ge};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_SAT: begin
                if (neg_reg) begin
                    if (q_hi || q_lo > RATE_MIN) begin
                        sat_next  = 1'b1;
                        rate_next = RATE_MIN;
                    end else begin
                        rate_next = 64'd0 - q_lo;
                    end
                end else begin
                    if (q_hi || q_lo[63]) begin
                        sat_next  = 1'b1;
                        rate_next = RATE_MAX;
                    end else begin
                        rate_next = q_lo;
                    end
                end
            end
            ST_BOUND: begin
                status_next = sat_reg ? STATUS_SAT : STATUS_VALID;
                if (mode_reg != MODE_IGNORE && (below || above)) begin
                    if (mode_reg == MODE_CLAMP) begin
                        rate_next = below ? min_reg : max_reg;
                    end else begin
                        rate_next   = '0;
                        status_next = STATUS_DISCARD;
                    end
                end
            end
            ST_OUT: begin
                if (out_space) begin
                    out_next.rate   = rate_reg;
                    out_next.status = status_reg;
                    m_valid_next    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            kind_reg       <= KIND_GAUGE;
            mode_reg       <= MODE_IGNORE;
            min_reg        <= RATE_MIN;
            max_reg        <= RATE_MAX;
            prev_time_reg  <= '0;
            prev_value_reg <= '0;
            prev_known_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            prev_time_reg  <= prev_time_next;
            prev_value_reg <= prev_value_next;
            prev_known_reg <= prev_known_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_SOURCE_KIND: kind_reg <= cfg_data[1:0];
                    REG_RANGE_MODE:  mode_reg <= cfg_data[1:0];
                    REG_MIN_RATE:    min_reg  <= cfg_data;
                    REG_MAX_RATE:    max_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
        dt_reg     <= dt_next;
        d_reg      <= d_next;
        nd_reg     <= nd_next;
        borrow_reg <= borrow_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        rate_reg   <= rate_next;
        status_reg <= status_next;
        sat_reg    <= sat_next;
        out_reg    <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

endmodule

FILE: sim/tb_counter_rate_converter_unit.sv
`timescale 1ns / 1ps

module tb_counter_rate_converter_unit;
    import crconv_pkg::*;

    localparam int          FRAC        = FRACTION_BITS_DEF;
    localparam logic [47:0] TIME_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          PHASES      = 15;
    localparam int          PHASE_ITEMS = 84;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_item;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [63:0] cfg_data;

    int src_idle;
    int snk_idle;
    int unsigned cycle_count = 0;

    counter_rate_converter_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    class rate_scoreboard;
        logic [1:0]  kind;
        logic [1:0]  mode;
        logic [63:0] lo_bound;
        logic [63:0] hi_bound;
        logic [47:0] prev_time;
        logic [63:0] prev_value;
        logic        prev_known;
        out_item_t   expected_rates[$];
        int          mismatches;

        function new();
            kind       = KIND_GAUGE;
            mode       = MODE_IGNORE;
            lo_bound   = RATE_MIN;
            hi_bound   = RATE_MAX;
            prev_time  = '0;
            prev_value = '0;
            prev_known = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] data);
            case (idx)
                REG_SOURCE_KIND: kind = data[1:0];
                REG_RANGE_MODE:  mode = data[1:0];
                REG_MIN_RATE:    lo_bound = data;
                default:         hi_bound = data;
            endcase
        endfunction

        // (mag * 1000 * 2^FRAC / dt), truncated, signed and saturated
        function logic [63:0] scale_rate(input logic [63:0] mag, input logic [47:0] dt,
                                         input bit neg, output bit sat);
            logic [127:0] num;
            logic [127:0] quo;
            num = 128'(mag) * (128'(1000) << FRAC);
            quo = num / 128'(dt);
            sat = 1'b0;
            if (neg) begin
                if (quo[127:64] != '0 || quo[63:0] > RATE_MIN) begin
                    sat = 1'b1;
                    return RATE_MIN;
                end
                return 64'd0 - quo[63:0];
            end
            if (quo[127:64] != '0 || quo[63:0] > RATE_MAX) begin
                sat = 1'b1;
                return RATE_MAX;
            end
            return quo[63:0];
        endfunction

        function out_item_t predict_rate(in_item_t it);
            out_item_t   res;
            logic [63:0] rate;
            logic [63:0] diff;
            logic [63:0] v;
            logic [47:0] dt;
            bit          sat;
            bit          have;
            bit          below;
            bit          above;
            res.rate   = '0;
            res.status = STATUS_NONE;
            v = it.sample_value;
            if (!it.value_present)
                return res;
            if (kind != KIND_GAUGE && prev_time >= it.sample_time)
                return res;
            sat  = 1'b0;
            have = 1'b1;
            rate = '0;
            if (kind == KIND_GAUGE) begin
                if (v > (RATE_MAX >> FRAC)) begin
                    sat  = 1'b1;
                    rate = RATE_MAX;
                end else begin
                    rate = v << FRAC;
                end
            end else begin
                dt = it.sample_time - prev_time;
                if (kind == KIND_ABSOLUTE) begin
                    rate = scale_rate(v, dt, 1'b0, sat);
                end else if (!prev_known) begin
                    have = 1'b0;
                end else if (kind == KIND_COUNTER) begin
                    if (v >= prev_value)
                        diff = v - prev_value;
                    else if (prev_value - v <= 64'(WRAP32))
                        diff = 64'(WRAP32) - (prev_value - v);
                    else
                        diff = v - prev_value;
                    rate = scale_rate(diff, dt, 1'b0, sat);
                end else if (v >= prev_value) begin
                    rate = scale_rate(v - prev_value, dt, 1'b0, sat);
                end else begin
                    rate = scale_rate(prev_value - v, dt, 1'b1, sat);
                end
            end
            prev_time  = it.sample_time;
            prev_value = v;
            prev_known = 1'b1;
            if (!have)
                return res;
            if (mode != MODE_IGNORE) begin
                below = $signed(rate) < $signed(lo_bound);
                above = !below && ($signed(hi_bound) < $signed(rate));
                if (below || above) begin
                    if (mode == MODE_CLAMP) begin
                        rate = below ? lo_bound : hi_bound;
                    end else begin
                        res.status = STATUS_DISCARD;
                        return res;
                    end
                end
            end
            res.rate   = rate;
            res.status = sat ? STATUS_SAT : STATUS_VALID;
            return res;
        endfunction

        function void note_sample(in_item_t it);
            expected_rates.push_back(predict_rate(it));
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_item;
            if (expected_rates.size() == 0) begin
                flag($sformatf("unexpected item: rate %h status %0d", got.rate, got.status));
                return;
            end
            exp_item = expected_rates.pop_front();
            if (got.rate !== exp_item.rate)
                flag($sformatf("rate mismatch: expected %h, got %h", exp_item.rate, got.rate));
            if (got.status !== exp_item.status)
                flag($sformatf("status mismatch: expected %0d, got %0d",
                               exp_item.status, got.status));
        endfunction

        function int outstanding();
            return expected_rates.size();
        endfunction
    endclass

    rate_scoreboard sb;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: check accepted items, then pick ready for the next cycle
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_item);
            m_ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    function automatic in_item_t mk(logic [47:0] t, logic [63:0] v, logic present);
        in_item_t it;
        it.sample_time   = t;
        it.sample_value  = v;
        it.value_present = present;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_bound(bit upper);
        logic [63:0] b;
        case ($urandom_range(3))
            0: return upper ? RATE_MAX : RATE_MIN;
            1: return rand64();
            2: begin
                b = 64'($urandom_range(1, 1000000)) << FRAC;
                return upper ? b : 64'd0 - b;
            end
            default: begin
                b = 64'($urandom) << $urandom_range(0, 24);
                return (upper || $urandom_range(1) == 0) ? b : 64'd0 - b;
            end
        endcase
    endfunction

    // mostly advancing samples with counter-like values, some noise
    function automatic in_item_t gen_sample();
        logic [47:0] pt;
        logic [47:0] dt;
        logic [47:0] t;
        logic [63:0] pv;
        logic [63:0] v;
        int          r;
        pt = sb.prev_time;
        pv = sb.prev_value;
        r  = $urandom_range(99);
        if (r < 4)
            return mk(48'(rand64()), rand64(), 1'b0);
        if (r < 9)
            return mk((pt >= 3) ? pt - 48'($urandom_range(3)) : pt, rand64(), 1'b1);
        if (r < 12)
            return mk(48'(rand64()), rand64(), 1'b1);
        dt = ($urandom_range(9) == 0) ? 48'($urandom) : 48'($urandom_range(1, 5000));
        if (dt == '0)
            dt = 48'd1;
        t = (pt > TIME_MAX - dt) ? TIME_MAX : pt + dt;
        r = $urandom_range(9);
        if (r < 6)
            v = pv + 64'($urandom_range(0, 1 << 24));
        else if (r == 6)
            v = pv - 64'($urandom_range(0, 1 << 24));
        else if (r == 7)
            v = pv - (64'(WRAP32) + 64'($urandom_range(0, 2)) - 64'd1);
        else if (r == 8)
            v = ($urandom_range(1) == 0) ? 64'($urandom_range(0, 15))
                                         : ~64'($urandom_range(0, 15));
        else
            v = rand64();
        return mk(t, v, 1'b1);
    endfunction

    // valid stays high across back-to-back items; lowered only on an idle cycle or to reconfigure
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(it);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic configure(input logic [1:0] kind, input logic [1:0] mode,
                             input logic [63:0] lo, input logic [63:0] hi);
        s_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        write_reg(REG_SOURCE_KIND, {62'(rand64()), kind});
        write_reg(REG_RANGE_MODE, {62'(rand64()), mode});
        write_reg(REG_MIN_RATE, lo);
        write_reg(REG_MAX_RATE, hi);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int p;
        int n;
        sb = new();
        src_idle = 25;
        snk_idle = 49;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_item    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SOURCE_KIND;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // counter: first sample has no predecessor, refusals, both wrap paths
        configure(KIND_COUNTER, MODE_IGNORE, RATE_MIN, RATE_MAX);
        send_item(mk(48'd1000, 64'd100, 1'b1));
        send_item(mk(48'd1000, 64'd200, 1'b1));
        send_item(mk(48'd500, 64'd300, 1'b1));
        send_item(mk(48'd2000, 64'd1100, 1'b0));
        send_item(mk(48'd2000, 64'd1100, 1'b1));
        send_item(mk(48'd3000, 64'd50, 1'b1));
        send_item(mk(48'd3001, '1, 1'b1));
        send_item(mk(48'd3002, 64'd5, 1'b1));
        send_item(mk(48'd3003, 64'h2_0000_0000, 1'b1));
        send_item(mk(48'd3004, 64'h1_0000_0000, 1'b1));

        // derive: negative, saturation both ways, last time step
        configure(KIND_DERIVE, MODE_IGNORE, RATE_MIN, RATE_MAX);
        send_item(mk(48'd4000, 64'hFFFF_FC18, 1'b1));
        send_item(mk(48'd4001, '1, 1'b1));
        send_item(mk(48'd4002, 64'd0, 1'b1));
        send_item(mk(TIME_MAX, 64'd0, 1'b1));

        configure(KIND_ABSOLUTE, MODE_IGNORE, RATE_MIN, RATE_MAX);
        send_item(mk(TIME_MAX, 64'd7, 1'b1));

        // gauge: a missing value after time goes back, saturation edge
        configure(KIND_GAUGE, MODE_IGNORE, RATE_MIN, RATE_MAX);
        send_item(mk(48'd0, 64'd0, 1'b1));
        send_item(mk(48'd5, 64'h7FFF_FFFF_FFFF, 1'b1));
        send_item(mk(48'd6, 64'h8000_0000_0000, 1'b1));
        send_item(mk(48'd2, '1, 1'b0));

        configure(KIND_ABSOLUTE, MODE_DISCARD, 64'd0, 64'd1000 << FRAC);
        send_item(mk(48'd1000, 64'd100, 1'b1));
        send_item(mk(48'd1001, 64'd10, 1'b1));

        configure(KIND_DERIVE, MODE_CLAMP, 64'd0 - (64'd10 << FRAC), 64'd10 << FRAC);
        send_item(mk(48'd2001, 64'd0, 1'b1));
        send_item(mk(48'd2002, 64'd10, 1'b1));
        send_item(mk(48'd2003, 64'd0, 1'b1));

        // saturated and clamped
        configure(KIND_ABSOLUTE, MODE_CLAMP, 64'd0, 64'd1 << FRAC);
        send_item(mk(48'd2004, '1, 1'b1));

        for (p = 0; p < PHASES; p++) begin
            if (p == 5) begin
                src_idle = 49;
                snk_idle = 25;
            end else if (p == 10) begin
                src_idle = 0;
                snk_idle = 0;
            end
            if (p == 0)
                configure(KIND_DERIVE, MODE_CLAMP, RATE_MIN, RATE_MAX);
            else if (p == PHASES - 1)
                configure(KIND_COUNTER, MODE_DISCARD, RATE_MAX, RATE_MIN);
            else
                configure(2'(p % 4), 2'($urandom_range(2)), rand_bound(1'b0), rand_bound(1'b1));
            for (n = 0; n < PHASE_ITEMS; n++)
                send_item(gen_sample());
        end

        s_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
